// ===== hdl/chacha_pkg.sv =====
// Shared types and constants for the ChaCha20 stream cipher block.
// Used by chacha_arx, chacha_core and chacha20_stream_cipher; depends on nothing.
`default_nettype none

package chacha_pkg;

    typedef logic [31:0]        word_t;
    typedef logic [15:0][31:0]  block_t;

    // The four steps of one quarter round, in order. Even steps update a and d,
    // odd steps update c and b; each has its own rotate distance.
    typedef enum logic [1:0] {
        QR_AD16 = 2'd0,
        QR_CB12 = 2'd1,
        QR_AD8  = 2'd2,
        QR_CB7  = 2'd3
    } qr_step_t;

    localparam int CFG_INDEX_W = 3;

    // Configuration register indexes. Index 7 has no register and is ignored.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_WORDS_0_1   = 3'd0,
        CFG_KEY_WORDS_2_3   = 3'd1,
        CFG_KEY_WORDS_4_5   = 3'd2,
        CFG_KEY_WORDS_6_7   = 3'd3,
        CFG_NONCE_LOW       = 3'd4,
        CFG_NONCE_HIGH      = 3'd5,
        CFG_INITIAL_COUNTER = 3'd6
    } cfg_index_t;

    // "expand 32-byte k", little-endian words; SIGMA[0] is state word 0.
    localparam logic [3:0][31:0] SIGMA = {
        32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
    };

endpackage

`default_nettype wire

// ===== hdl/chacha_arx.sv =====
// Shared add-rotate-xor unit: one step of a ChaCha quarter round per cycle.
// Depends on chacha_pkg.
`default_nettype none

module chacha_arx (
    input  chacha_pkg::word_t    x_in,
    input  chacha_pkg::word_t    y_in,
    input  chacha_pkg::word_t    z_in,
    input  chacha_pkg::qr_step_t step_in,
    output chacha_pkg::word_t    sum_out,
    output chacha_pkg::word_t    mix_out
);
    import chacha_pkg::*;

    word_t mixed;

    assign sum_out = x_in + y_in;
    assign mixed   = z_in ^ sum_out;

    always_comb begin
        unique case (step_in)
            QR_AD16: mix_out = {mixed[15:0], mixed[31:16]};
            QR_CB12: mix_out = {mixed[19:0], mixed[31:20]};
            QR_AD8:  mix_out = {mixed[23:0], mixed[31:24]};
            QR_CB7:  mix_out = {mixed[24:0], mixed[31:25]};
            default: mix_out = mixed;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/chacha_core.sv =====
// Keystream block generator: sixteen-word state, round sequencer and the shared
// add-rotate-xor unit. Depends on chacha_pkg and chacha_arx.
`default_nettype none

module chacha_core #(
    parameter int ROUND_COUNT = 20
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               gen_go,
    input  chacha_pkg::block_t init_words,
    output logic               gen_done,
    output chacha_pkg::block_t ks_words
);
    import chacha_pkg::*;

    localparam int RCW = $clog2(ROUND_COUNT + 1);
    localparam logic [3:0] STEP_LAST = 4'hF;

    typedef enum logic [4:0] {
        C_IDLE   = 5'b00001,
        C_ROUND  = 5'b00010,
        C_SKEW   = 5'b00100,
        C_UNSKEW = 5'b01000,
        C_ADD    = 5'b10000
    } core_state_t;

    core_state_t    state_reg, state_next;
    block_t         w_reg, w_next, upd;
    logic [RCW-1:0] round_reg, round_next;
    logic [3:0]     step_reg, step_next;
    qr_step_t       qr_step;
    logic           cb_step;
    word_t          arx_x, arx_y, arx_z, arx_sum, arx_mix;

    // The quarter round always works on column 0 (words 0, 4, 8, 12). Rotating
    // every row left by one word after each quarter round brings the next
    // column into place; skewing row r by r words turns diagonals into columns.
    assign qr_step = qr_step_t'(step_reg[1:0]);
    assign cb_step = (qr_step == QR_CB12) || (qr_step == QR_CB7);

    always_comb begin
        arx_x = cb_step ? w_reg[8]  : w_reg[0];
        arx_y = cb_step ? w_reg[12] : w_reg[4];
        arx_z = cb_step ? w_reg[4]  : w_reg[12];
        if (state_reg == C_ADD) begin
            arx_x = w_reg[0];
            arx_y = init_words[step_reg];
        end
    end

    chacha_arx u_arx (
        .x_in    (arx_x),
        .y_in    (arx_y),
        .z_in    (arx_z),
        .step_in (qr_step),
        .sum_out (arx_sum),
        .mix_out (arx_mix)
    );

    always_comb begin
        state_next = state_reg;
        w_next     = w_reg;
        round_next = round_reg;
        step_next  = step_reg;
        upd        = w_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (gen_go) begin
                    w_next     = init_words;
                    round_next = '0;
                    step_next  = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND: begin
                if (cb_step) begin
                    upd[8] = arx_sum;
                    upd[4] = arx_mix;
                end else begin
                    upd[0]  = arx_sum;
                    upd[12] = arx_mix;
                end
                if (qr_step == QR_CB7) begin
                    for (int r = 0; r < 4; r++) begin
                        for (int j = 0; j < 4; j++) begin
                            w_next[4*r + j] = upd[4*r + ((j + 1) % 4)];
                        end
                    end
                end else begin
                    w_next = upd;
                end
                step_next = step_reg + 4'd1;
                if (step_reg == STEP_LAST) begin
                    round_next = round_reg + RCW'(1);
                    if (round_reg[0]) begin
                        state_next = C_UNSKEW;
                    end else if (round_next == RCW'(ROUND_COUNT)) begin
                        state_next = C_ADD;
                    end else begin
                        state_next = C_SKEW;
                    end
                end
            end
            C_SKEW: begin
                for (int r = 0; r < 4; r++) begin
                    for (int j = 0; j < 4; j++) begin
                        w_next[4*r + j] = w_reg[4*r + ((j + r) % 4)];
                    end
                end
                state_next = C_ROUND;
            end
            C_UNSKEW: begin
                for (int r = 0; r < 4; r++) begin
                    for (int j = 0; j < 4; j++) begin
                        w_next[4*r + j] = w_reg[4*r + ((j + 4 - r) % 4)];
                    end
                end
                state_next = (round_reg == RCW'(ROUND_COUNT)) ? C_ADD : C_ROUND;
            end
            C_ADD: begin
                // Feed-forward as a shift line: word k passes position 0 at step k.
                for (int i = 0; i < 15; i++) begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[15] = arx_sum;
                step_next  = step_reg + 4'd1;
                if (step_reg == STEP_LAST) begin
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg <= w_next;
    end

    assign gen_done = (state_reg == C_ADD) && (step_reg == STEP_LAST);
    assign ks_words = w_reg;

endmodule

`default_nettype wire

// ===== hdl/chacha20_stream_cipher.sv =====
// ChaCha20 stream cipher top level: configuration registers, byte handshake,
// keystream byte selection. Depends on chacha_pkg and chacha_core.
`default_nettype none

// ChaCha20 (RFC 8439 layout: 256-bit key, 32-bit block counter, 96-bit nonce)
// applied to a byte stream. Each input transfer carries one data byte and a
// start flag; each output transfer carries that byte xored with the next
// keystream byte, in order, one result per input. A set start flag reloads the
// block counter from initial_counter and restarts at keystream byte 0 before
// the byte is processed; without any start after reset the stream runs from
// counter 0. The counter advances every 64 bytes and wraps silently at 2^32.
// Key and nonce are sampled whenever a block is generated, so a change takes
// effect from the next block; initial_counter takes effect at the next start.
// Configuration is written over the cfg_* channel, index 0 to 6 in the order
// key words 0/1, 2/3, 4/5, 6/7, nonce low, nonce high, initial counter (low
// 32 bits of cfg_data for the 32-bit ones); index 7 is ignored. cfg_ready is
// always high, and configuration must only be written while no byte is in
// flight. The block handles one byte at a time. A byte whose keystream block
// is already held is accepted, then its result goes into the output register
// once that is free. The first byte of each 64-byte block, and the first byte
// after a start, waits for block generation in a single shared add-rotate-xor
// unit that does one quarter-round step per cycle: the rounds step by step, a
// row rotation after each round bar a final column round, then the feed-forward
// addition. A new byte is accepted while the previous result still waits in
// the output register.
module chacha20_stream_cipher #(
    parameter int ROUND_COUNT = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [chacha_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [63:0]                         cfg_data,
    // Input byte channel.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_start_message,
    // Result byte channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_cipher_byte
);
    import chacha_pkg::*;

    localparam logic [5:0] POS_LAST = 6'd63;

    typedef enum logic [3:0] {
        T_IDLE   = 4'b0001,
        T_LAUNCH = 4'b0010,
        T_WAIT   = 4'b0100,
        T_EMIT   = 4'b1000
    } top_state_t;

    top_state_t       state_reg, state_next;

    // Configuration registers.
    logic [3:0][63:0] key_reg, key_next;
    logic [63:0]      nonce_low_reg, nonce_low_next;
    word_t            nonce_high_reg, nonce_high_next;
    word_t            init_ctr_reg, init_ctr_next;

    // Stream position.
    word_t            counter_reg, counter_next;
    logic [5:0]       pos_reg, pos_next;
    logic             ks_valid_reg, ks_valid_next;

    // Data path.
    logic [7:0]       data_reg, data_next;
    logic [7:0]       out_reg, out_next;
    logic             m_valid_reg, m_valid_next;

    logic             in_fire, out_free;
    logic             gen_go, gen_done;
    block_t           init_words, ks_words;
    word_t            ks_word_sel;
    logic [7:0]       ks_byte;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == T_IDLE);
    assign in_fire   = s_valid && s_ready;
    // The output register is free when empty or emptied in this cycle.
    assign out_free  = !m_valid_reg || m_ready;
    assign gen_go    = (state_reg == T_LAUNCH);

    // Initial state of a block: constants, key, counter, nonce.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            init_words[i]         = SIGMA[i];
            init_words[4 + 2*i]   = key_reg[i][31:0];
            init_words[5 + 2*i]   = key_reg[i][63:32];
        end
        init_words[12] = counter_reg;
        init_words[13] = nonce_low_reg[31:0];
        init_words[14] = nonce_low_reg[63:32];
        init_words[15] = nonce_high_reg;
    end

    chacha_core #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .gen_go     (gen_go),
        .init_words (init_words),
        .gen_done   (gen_done),
        .ks_words   (ks_words)
    );

    // Keystream bytes are taken little-endian from each word.
    assign ks_word_sel = ks_words[pos_reg[5:2]];
    assign ks_byte     = ks_word_sel[{pos_reg[1:0], 3'b000} +: 8];

    // Configuration writes.
    always_comb begin
        key_next        = key_reg;
        nonce_low_next  = nonce_low_reg;
        nonce_high_next = nonce_high_reg;
        init_ctr_next   = init_ctr_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_KEY_WORDS_0_1:   key_next[0]     = cfg_data;
                CFG_KEY_WORDS_2_3:   key_next[1]     = cfg_data;
                CFG_KEY_WORDS_4_5:   key_next[2]     = cfg_data;
                CFG_KEY_WORDS_6_7:   key_next[3]     = cfg_data;
                CFG_NONCE_LOW:       nonce_low_next  = cfg_data;
                CFG_NONCE_HIGH:      nonce_high_next = cfg_data[31:0];
                CFG_INITIAL_COUNTER: init_ctr_next   = cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Byte sequencer. A start flag is applied in the accept cycle, so the
    // decision whether a new block is needed already sees its effect.
    always_comb begin
        state_next    = state_reg;
        counter_next  = counter_reg;
        pos_next      = pos_reg;
        ks_valid_next = ks_valid_reg;
        data_next     = data_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            T_IDLE: begin
                if (in_fire) begin
                    data_next = s_data_byte;
                    if (s_start_message) begin
                        counter_next  = init_ctr_reg;
                        pos_next      = '0;
                        ks_valid_next = 1'b0;
                    end
                    state_next = (ks_valid_reg && !s_start_message) ? T_EMIT : T_LAUNCH;
                end
            end
            T_LAUNCH: state_next = T_WAIT;
            T_WAIT: begin
                if (gen_done) begin
                    ks_valid_next = 1'b1;
                    state_next    = T_EMIT;
                end
            end
            T_EMIT: begin
                if (out_free) begin
                    out_next     = data_reg ^ ks_byte;
                    m_valid_next = 1'b1;
                    pos_next     = pos_reg + 6'd1;
                    if (pos_reg == POS_LAST) begin
                        counter_next  = counter_reg + 32'd1;
                        ks_valid_next = 1'b0;
                    end
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= T_IDLE;
            key_reg        <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
            init_ctr_reg   <= '0;
            counter_reg    <= '0;
            pos_reg        <= '0;
            ks_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            key_reg        <= key_next;
            nonce_low_reg  <= nonce_low_next;
            nonce_high_reg <= nonce_high_next;
            init_ctr_reg   <= init_ctr_next;
            counter_reg    <= counter_next;
            pos_reg        <= pos_next;
            ks_valid_reg   <= ks_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        out_reg  <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_cipher_byte = out_reg;

endmodule

`default_nettype wire

// ===== tb/chacha20_stream_cipher_tb.sv =====
// Self-checking testbench for chacha20_stream_cipher: directed and random byte traffic
// against a ChaCha20 keystream predictor held in the bench.
// Depends on chacha_pkg and the RTL under hdl; reads no files.
`default_nettype none

module chacha20_stream_cipher_tb;

    import chacha_pkg::*;

    // The predictor follows this parameter, odd round counts included, so the
    // bench can be rebuilt for a reduced-round core without further edits.
    parameter int ROUND_COUNT = 20;

    // Span of one block generation, used to size the end slack.
    localparam int BLOCK_CYCLES  = 17 * ROUND_COUNT + 19;
    localparam int RANDOM_ITEMS  = 1050;
    // Worst case per byte is a fresh block, the longest sender gap and the
    // longest receiver stall; the limit is several times that over all bytes.
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int END_SLACK     = 2 * BLOCK_CYCLES;

    // The one index that has no register behind it; writes to it are ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_REGISTER = 3'd7;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_CHOPPY,
        RX_BURSTY
    } rx_mode_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [63:0]             cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [7:0]              s_data_byte;
    logic                    s_start_message;
    logic                    m_valid;
    logic                    m_ready;
    logic [7:0]              m_cipher_byte;

    chacha20_stream_cipher #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_start_message (s_start_message),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cipher_byte   (m_cipher_byte)
    );

    // Shadow copies of the configuration registers, updated on each write
    // transfer exactly as the block should update its own.
    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] ctr_init_reg;

    // Keystream state of the predictor: the block currently held, the next
    // byte position within it, the block counter and whether the held block
    // may still be used.
    block_t      ks_words;
    logic [5:0]  ks_pos;
    word_t       ks_counter;
    bit          ks_valid;

    // Cipher bytes predicted at input acceptance, waiting for their result.
    logic [7:0]  pending_cipher_q [$];

    int          fail_count;
    int unsigned cycle_count;
    int          burst_left;
    bit          sender_steady;
    rx_mode_t    rx_mode;
    int          rx_stall_left;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic word_t rotl(input word_t v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // One quarter round on four words, returned as {a, b, c, d}.
    function automatic logic [127:0] quarter_round(input word_t a, input word_t b,
                                                   input word_t c, input word_t d);
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        return {a, b, c, d};
    endfunction

    // Builds the 64-byte keystream block for a given counter from the key and
    // nonce as they stand now, so register writes are picked up per block.
    function automatic block_t chacha_keystream_block(input word_t ctr);
        word_t  init_w [16];
        word_t  w [16];
        block_t blk;
        int     ia, ib, ic, id;
        for (int i = 0; i < 4; i++) begin
            init_w[i]         = SIGMA[i];
            init_w[4 + 2 * i] = key_reg[i][31:0];
            init_w[5 + 2 * i] = key_reg[i][63:32];
        end
        init_w[12] = ctr;
        init_w[13] = nonce_lo_reg[31:0];
        init_w[14] = nonce_lo_reg[63:32];
        init_w[15] = nonce_hi_reg;
        w = init_w;
        for (int r = 0; r < ROUND_COUNT; r++) begin
            for (int j = 0; j < 4; j++) begin
                // Even rounds work down the columns, odd rounds along the
                // diagonals, so an odd count finishes on a column round.
                ia = j;
                ib = 4 + ((r % 2 == 0) ? j : (j + 1) % 4);
                ic = 8 + ((r % 2 == 0) ? j : (j + 2) % 4);
                id = 12 + ((r % 2 == 0) ? j : (j + 3) % 4);
                {w[ia], w[ib], w[ic], w[id]} = quarter_round(w[ia], w[ib], w[ic], w[id]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            blk[i] = w[i] + init_w[i];
        end
        return blk;
    endfunction

    // Advances the predictor by one input byte and returns its cipher byte.
    function automatic logic [7:0] predict_cipher_byte(input logic [7:0] data,
                                                       input logic start_flag);
        logic [7:0] ks_byte;
        if (start_flag) begin
            ks_counter = ctr_init_reg;
            ks_pos     = '0;
            ks_valid   = 1'b0;
        end
        if (!ks_valid) begin
            ks_words = chacha_keystream_block(ks_counter);
            ks_valid = 1'b1;
        end
        ks_byte = ks_words[ks_pos[5:2]][{ks_pos[1:0], 3'b000} +: 8];
        ks_pos  = ks_pos + 6'd1;
        // Moving past the last byte of a block: the counter wraps silently.
        if (ks_pos == '0) begin
            ks_counter = ks_counter + 32'd1;
            ks_valid   = 1'b0;
        end
        return data ^ ks_byte;
    endfunction

    // ------------------------------------------------------------------
    // Clock, receiver and result checking
    // ------------------------------------------------------------------

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The receiver stalls on its own pattern: always ready, ready at random about
    // three quarters of the time, or mostly ready with occasional long stalls.
    always @(posedge aclk) begin
        if (rx_stall_left != 0) begin
            m_ready       <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else begin
            case (rx_mode)
                RX_ALWAYS: begin
                    m_ready <= 1'b1;
                end
                RX_CHOPPY: begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        m_ready       <= 1'b0;
                        rx_stall_left <= $urandom_range(1, 24);
                    end else begin
                        m_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Every result transfer is matched against the oldest prediction.
    always @(posedge aclk) begin : check_results
        logic [7:0] due;
        if (aresetn && m_valid && m_ready) begin
            if (pending_cipher_q.size() == 0) begin
                $display("%0t: unexpected cipher_byte, expected none, actual %02h",
                         $time, m_cipher_byte);
                fail_count++;
            end else begin
                due = pending_cipher_q.pop_front();
                if (m_cipher_byte !== due) begin
                    $display("%0t: cipher_byte mismatch, expected %02h, actual %02h",
                             $time, due, m_cipher_byte);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a run that overstays the limit is a failure.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL chacha20_stream_cipher");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    // Sender pacing, unless steady: bursts of random length separated by random
    // gaps, with an occasional long gap so idle time also lands mid block generation.
    task automatic pace_sender();
        int gap;
        if (!sender_steady) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 6);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
                burst_left = $urandom_range(0, 24);
            end
        end
    endtask

    // One byte transfer. Valid is left high so that a following byte can be
    // presented back to back; pacing lowers it when a gap is due.
    task automatic send_byte(input logic [7:0] data, input logic start_flag);
        s_valid         <= 1'b1;
        s_data_byte     <= data;
        s_start_message <= start_flag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_cipher_q.push_back(predict_cipher_byte(data, start_flag));
        pace_sender();
    endtask

    task automatic send_message(input int len, input bit with_start, input bit allow_stray);
        logic start_flag;
        for (int n = 0; n < len; n++) begin
            start_flag = (n == 0 && with_start)
                      || (allow_stray && $urandom_range(0, 63) == 0);
            send_byte(8'($urandom_range(0, 255)), start_flag);
        end
    endtask

    // Holds off until every predicted byte has come back, so that the block
    // is idle and configuration may be written.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (pending_cipher_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One configuration write transfer. Valid stays high for a following
    // write; cfg_release lowers it after the last one of a batch.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_KEY_WORDS_0_1, CFG_KEY_WORDS_2_3,
            CFG_KEY_WORDS_4_5, CFG_KEY_WORDS_6_7: key_reg[idx[1:0]] = value;
            CFG_NONCE_LOW:       nonce_lo_reg = value;
            CFG_NONCE_HIGH:      nonce_hi_reg = value[31:0];
            CFG_INITIAL_COUNTER: ctr_init_reg = value[31:0];
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
    endtask

    // Register values lean towards the extremes; the third choice puts the
    // low word at its maximum so that the counter wraps within a message.
    function automatic logic [63:0] pick_reg_value();
        case ($urandom_range(0, 7))
            0:       return 64'h0;
            1:       return {64{1'b1}};
            2:       return {32'($urandom), 32'hFFFF_FFFF};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset with every register at zero and no start flag at all,
    // the stream must run from counter zero and keystream byte zero.
    task automatic test_no_start_after_reset();
        rx_mode       = RX_ALWAYS;
        sender_steady = 1'b1;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_until_drained();
    endtask

    // Every index written with all ones, the unused index included, then
    // with all zeros; a short message follows each setting.
    task automatic test_register_extremes();
        rx_mode       = RX_CHOPPY;
        sender_steady = 1'b0;
        for (int i = 0; i < (1 << CFG_INDEX_W); i++) begin
            write_reg(i[CFG_INDEX_W-1:0], {64{1'b1}});
        end
        cfg_release();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_until_drained();
        for (int i = 0; i < (1 << CFG_INDEX_W); i++) begin
            write_reg(i[CFG_INDEX_W-1:0], 64'h0);
        end
        cfg_release();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        wait_until_drained();
    endtask

    // Start flags on consecutive bytes each drop the held block and restart
    // at byte zero; a start part way into a block does the same.
    task automatic test_restart_on_start();
        rx_mode       = RX_BURSTY;
        sender_steady = 1'b1;
        write_reg(CFG_INITIAL_COUNTER, {32'($urandom), 32'($urandom)});
        write_reg(CFG_NO_REGISTER, {32'($urandom), 32'($urandom)});
        cfg_release();
        repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_until_drained();
    endtask

    // A message long enough to cross from counter 2^32-1 into counter zero.
    task automatic test_counter_wrap();
        rx_mode       = RX_CHOPPY;
        sender_steady = 1'b0;
        write_reg(CFG_KEY_WORDS_2_3, {32'($urandom), 32'($urandom)});
        write_reg(CFG_NONCE_LOW, {32'($urandom), 32'($urandom)});
        write_reg(CFG_INITIAL_COUNTER, 64'hFFFF_FFFF);
        cfg_release();
        send_message(70, 1'b1, 1'b0);
        wait_until_drained();
    endtask

    // Key and nonce rewritten part way into a message: the held block keeps
    // the old values and the next block takes the new ones. A new initial
    // counter only shows at the following start.
    task automatic test_rekey_mid_message();
        rx_mode       = RX_BURSTY;
        sender_steady = 1'b0;
        send_message(10, 1'b1, 1'b0);
        wait_until_drained();
        write_reg(CFG_KEY_WORDS_0_1, {32'($urandom), 32'($urandom)});
        write_reg(CFG_KEY_WORDS_6_7, {32'($urandom), 32'($urandom)});
        write_reg(CFG_NONCE_HIGH, {32'($urandom), 32'($urandom)});
        write_reg(CFG_INITIAL_COUNTER, {32'($urandom), 32'($urandom)});
        cfg_release();
        send_message(60, 1'b0, 1'b0);
        send_message(3, 1'b1, 1'b0);
        wait_until_drained();
    endtask

    // Random phases: fresh register settings while idle, a receiver pattern
    // and a sender style per phase, then a few messages of random length.
    // Most messages open with a start flag; some carry on without one and
    // some carry stray starts.
    task automatic test_random_traffic();
        int sent;
        int len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_until_drained();
            for (int i = 0; i < (1 << CFG_INDEX_W); i++) begin
                if ($urandom_range(0, 1) == 1) begin
                    write_reg(i[CFG_INDEX_W-1:0], pick_reg_value());
                end
            end
            cfg_release();
            rx_mode       = rx_mode_t'($urandom_range(0, 2));
            sender_steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4)) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 90);
                send_message(len, $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0);
                sent += len;
            end
        end
        wait_until_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        for (int i = 0; i < 4; i++) begin
            key_reg[i] = '0;
        end
        nonce_lo_reg  = '0;
        nonce_hi_reg  = '0;
        ctr_init_reg  = '0;
        ks_words      = '0;
        ks_pos        = '0;
        ks_counter    = '0;
        ks_valid      = 1'b0;
        fail_count    = 0;
        burst_left    = 0;
        sender_steady = 1'b1;
        rx_mode       = RX_ALWAYS;
        rx_stall_left = 0;

        aresetn         <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        s_valid         <= 1'b0;
        s_data_byte     <= '0;
        s_start_message <= 1'b0;
        m_ready         <= 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_no_start_after_reset();
        test_register_extremes();
        test_restart_on_start();
        test_counter_wrap();
        test_rekey_mid_message();
        test_random_traffic();

        // Give a stray result time to show before judging the run.
        repeat (END_SLACK) @(posedge aclk);
        if (fail_count == 0 && pending_cipher_q.size() == 0) begin
            $display("PASS chacha20_stream_cipher");
        end else begin
            $display("FAIL chacha20_stream_cipher");
        end
        $finish;
    end

endmodule

`default_nettype wire
